// ----- design/mrcc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the Modbus response checker.
package mrcc_pkg;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [2:0]  CRC_SPAN      = 3'd5;
  localparam logic [2:0]  POS_HIGH      = 3'd3;
  localparam logic [2:0]  POS_LOW       = 3'd4;
  localparam logic [2:0]  POS_CRC_LOW   = 3'd5;
  localparam logic [2:0]  POS_LAST      = 3'd6;
  localparam logic [16:0] ELAPSED_MAX   = 17'h1FFFF;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_TIMEOUT  = 2'd2
  } status_t;

  // One registered word waiting for the core
  typedef struct packed {
    logic       valid;
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } item_t;

  // Reflected CRC-16 over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/mrcc_if.sv -----
// Valid/ready channel interfaces for received words and check results.
interface mrcc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface mrcc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] reading;

  modport source (output valid, output status, output reading, input ready);
  modport sink   (input valid, input status, input reading, output ready);
endinterface

// ----- design/mrcc_in_reg.sv -----
// Input register stage: captures one word and holds it until the core takes it.
module mrcc_in_reg
  import mrcc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  mrcc_item_if.sink frame,
  input  logic  take,
  output item_t item
);

  logic       valid;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  assign frame.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (frame.ready) begin
      valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.ready && frame.valid) begin
      operation <= frame.operation;
      rx_byte   <= frame.rx_byte;
    end
  end

  assign item = '{valid: valid, operation: operation, rx_byte: rx_byte};

endmodule

// ----- design/mrcc_core.sv -----
// Response state, CRC update, tick timeout and the result register.
module mrcc_core
  import mrcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        timeout_we,
  input  logic [15:0] timeout_data,
  input  item_t       item,
  output logic        take,
  mrcc_result_if.source verdict
);

  logic [15:0] timeout_ticks;
  logic        busy, busy_next;
  logic [2:0]  byte_position, byte_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] value_hold, value_hold_next;
  logic [7:0]  crc_low_hold, crc_low_hold_next;
  logic [16:0] elapsed_ticks, elapsed_ticks_next;

  logic        res_valid;
  status_t     res_status, res_status_next;
  logic [15:0] res_reading, res_reading_next;
  logic        produce;
  logic        fire;
  logic [15:0] rx_crc;

  // result slot free, so the waiting word can be processed this cycle
  assign take = !res_valid || verdict.ready;
  assign fire = take && item.valid;
  assign rx_crc = {item.rx_byte, crc_low_hold};

  always_comb begin
    busy_next          = busy;
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    value_hold_next    = value_hold;
    crc_low_hold_next  = crc_low_hold;
    elapsed_ticks_next = elapsed_ticks;
    produce            = 1'b0;
    res_status_next    = ST_OK;
    res_reading_next   = 16'h0000;
    case (op_t'(item.operation))
      OP_START: begin
        busy_next          = 1'b1;
        byte_position_next = 3'd0;
        running_crc_next   = CRC_INIT;
        value_hold_next    = 16'h0000;
        crc_low_hold_next  = 8'h00;
        elapsed_ticks_next = 17'd0;
      end
      OP_BYTE: begin
        if (busy) begin
          if (byte_position < CRC_SPAN) begin
            running_crc_next = crc_byte(running_crc, item.rx_byte);
          end
          if (byte_position == POS_HIGH) begin
            value_hold_next = {item.rx_byte, 8'h00};
          end else if (byte_position == POS_LOW) begin
            value_hold_next = {value_hold[15:8], item.rx_byte};
          end else if (byte_position == POS_CRC_LOW) begin
            crc_low_hold_next = item.rx_byte;
          end
          if (byte_position >= POS_LAST) begin
            busy_next          = 1'b0;
            byte_position_next = 3'd0;
            produce            = 1'b1;
            if (rx_crc == running_crc) begin
              res_status_next  = ST_OK;
              res_reading_next = value_hold;
            end else begin
              res_status_next  = ST_CRC_ERR;
            end
          end else begin
            byte_position_next = byte_position + 3'd1;
          end
        end
      end
      OP_TICK: begin
        if (busy) begin
          if (elapsed_ticks < ELAPSED_MAX) begin
            elapsed_ticks_next = elapsed_ticks + 17'd1;
          end
          if (elapsed_ticks_next > {1'b0, timeout_ticks}) begin
            busy_next          = 1'b0;
            byte_position_next = 3'd0;
            produce            = 1'b1;
            res_status_next    = ST_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (timeout_we) begin
      timeout_ticks <= timeout_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      byte_position <= 3'd0;
      running_crc   <= CRC_INIT;
      value_hold    <= 16'h0000;
      crc_low_hold  <= 8'h00;
      elapsed_ticks <= 17'd0;
    end else if (fire) begin
      busy          <= busy_next;
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      value_hold    <= value_hold_next;
      crc_low_hold  <= crc_low_hold_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= fire && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      res_status  <= res_status_next;
      res_reading <= res_reading_next;
    end
  end

  assign verdict.valid   = res_valid;
  assign verdict.status  = res_status;
  assign verdict.reading = res_reading;

endmodule

// ----- design/modbus_response_crc_checker.sv -----
// Top level of the Modbus RTU read-register response CRC checker.
//
//   channel   role    handshake      payload
//   frame     sink    valid/ready    operation[1:0], rx_byte[7:0]
//   verdict   source  valid/ready    status[1:0], reading[15:0]
//   timeout   config  timeout_we     timeout_data[15:0]
//
// One word is taken per cycle while no result waits to be taken. A word passes
// the input register, then the combinational CRC byte update, and its result
// is held in the result register until it is taken. Synchronous
// reset empties both registers, leaves the block idle and loads the timeout
// with 100. While a result waits to be taken the input register still takes
// one more word, then frame.ready drops until the result leaves.
module modbus_response_crc_checker
  import mrcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mrcc_item_if.sink   frame,
  mrcc_result_if.source verdict,
  input  logic        timeout_we,
  input  logic [15:0] timeout_data
);

  item_t item;
  logic  take;

  mrcc_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .frame (frame),
    .take  (take),
    .item  (item)
  );

  mrcc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .timeout_we   (timeout_we),
    .timeout_data (timeout_data),
    .item         (item),
    .take         (take),
    .verdict      (verdict)
  );

endmodule
